[hw/rtl/seqbm_pkg.sv]
// ----------------------------------------------------------------------------
// seqbm_pkg
// Shared types, constants and the control program of the sequence block mover.
// ----------------------------------------------------------------------------
package seqbm_pkg;

  // store geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 11;
  localparam int DATA_W = 32;
  // signed width for position arithmetic, wide enough for b - a - len
  localparam int CALC_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;
  localparam int PC_W   = 5;

  // request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_MOVE   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // input transaction
  typedef struct packed {
    logic        [1:0]       req_type;
    logic signed [DATA_W-1:0] value_in;
    logic        [POS_W-1:0]  start_pos;
    logic        [POS_W-1:0]  block_len;
    logic        [POS_W-1:0]  target_pos;
  } in_t;

  // result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic                     status;
  } out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_APPEND,
    OP_RD_ADDR,
    OP_RD_OUT,
    OP_CLIP_P,
    OP_CLIP_Q,
    OP_SET_BACK,
    OP_SET_FWD0,
    OP_SET_FWD1,
    OP_INIT1,
    OP_INIT2,
    OP_INIT3,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_DRAIN
  } op_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_FWD,
    JC_DONE
  } jc_t;

  // control word
  typedef struct packed {
    op_t             op;
    jc_t             cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } ctl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic fwd;   // destination at or after block start
    logic done;  // current reversal span has no pair left
  } flags_t;

  // program entry points and branch targets
  localparam logic [PC_W-1:0] UA_ADD   = 5'd0;
  localparam logic [PC_W-1:0] UA_RD    = 5'd1;
  localparam logic [PC_W-1:0] UA_NOP   = 5'd3;
  localparam logic [PC_W-1:0] UA_MV    = 5'd4;
  localparam logic [PC_W-1:0] UA_FWD   = 5'd7;
  localparam logic [PC_W-1:0] UA_R1    = 5'd9;
  localparam logic [PC_W-1:0] UA_R1A   = 5'd10;
  localparam logic [PC_W-1:0] UA_R1D   = 5'd12;
  localparam logic [PC_W-1:0] UA_R2A   = 5'd14;
  localparam logic [PC_W-1:0] UA_R2D   = 5'd16;
  localparam logic [PC_W-1:0] UA_R3A   = 5'd18;
  localparam logic [PC_W-1:0] UA_R3D   = 5'd20;

  localparam ctl_t CTL_IDLE = '{op: OP_IDLE, cond: JC_NEXT, target: '0, fin: 1'b0};

  // entry point for a request
  function automatic logic [PC_W-1:0] dispatch(input logic [1:0] req);
    logic [PC_W-1:0] pc;
    unique case (req)
      REQ_APPEND: pc = UA_ADD;
      REQ_MOVE:   pc = UA_MV;
      REQ_READ:   pc = UA_RD;
      default:    pc = UA_NOP;
    endcase
    return pc;
  endfunction

  // control store
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    unique case (pc)
      5'd0:  w = '{op: OP_APPEND,   cond: JC_NEXT,   target: '0,     fin: 1'b1};
      5'd1:  w = '{op: OP_RD_ADDR,  cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd2:  w = '{op: OP_RD_OUT,   cond: JC_NEXT,   target: '0,     fin: 1'b1};
      5'd3:  w = '{op: OP_NOP,      cond: JC_NEXT,   target: '0,     fin: 1'b1};
      5'd4:  w = '{op: OP_CLIP_P,   cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd5:  w = '{op: OP_CLIP_Q,   cond: JC_FWD,    target: UA_FWD, fin: 1'b0};
      5'd6:  w = '{op: OP_SET_BACK, cond: JC_ALWAYS, target: UA_R1,  fin: 1'b0};
      5'd7:  w = '{op: OP_SET_FWD0, cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd8:  w = '{op: OP_SET_FWD1, cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd9:  w = '{op: OP_INIT1,    cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd10: w = '{op: OP_SWAP_A,   cond: JC_DONE,   target: UA_R1D, fin: 1'b0};
      5'd11: w = '{op: OP_SWAP_B,   cond: JC_ALWAYS, target: UA_R1A, fin: 1'b0};
      5'd12: w = '{op: OP_DRAIN,    cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd13: w = '{op: OP_INIT2,    cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd14: w = '{op: OP_SWAP_A,   cond: JC_DONE,   target: UA_R2D, fin: 1'b0};
      5'd15: w = '{op: OP_SWAP_B,   cond: JC_ALWAYS, target: UA_R2A, fin: 1'b0};
      5'd16: w = '{op: OP_DRAIN,    cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd17: w = '{op: OP_INIT3,    cond: JC_NEXT,   target: '0,     fin: 1'b0};
      5'd18: w = '{op: OP_SWAP_A,   cond: JC_DONE,   target: UA_R3D, fin: 1'b0};
      5'd19: w = '{op: OP_SWAP_B,   cond: JC_ALWAYS, target: UA_R3A, fin: 1'b0};
      5'd20: w = '{op: OP_DRAIN,    cond: JC_NEXT,   target: '0,     fin: 1'b1};
      default: w = '{op: OP_NOP,    cond: JC_NEXT,   target: '0,     fin: 1'b1};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/seqbm_ram.sv]
// ----------------------------------------------------------------------------
// seqbm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module seqbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/seqbm_seq.sv]
// ----------------------------------------------------------------------------
// seqbm_seq
// Microcode sequencer: step counter, control store lookup and jumps.
// ----------------------------------------------------------------------------
module seqbm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [1:0]        req_type,
  input  seqbm_pkg::flags_t flags,
  output seqbm_pkg::ctl_t   ctl,
  output logic              busy
);
  import seqbm_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  // current control word
  assign ctl  = busy_r ? ucode(pc_r) : CTL_IDLE;
  assign busy = busy_r;

  // jump condition select
  always_comb begin
    unique case (ctl.cond)
      JC_NEXT:   jump = 1'b0;
      JC_ALWAYS: jump = 1'b1;
      JC_FWD:    jump = flags.fwd;
      JC_DONE:   jump = flags.done;
    endcase
  end

  // next step
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (go) begin
      pc_nxt   = dispatch(req_type);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      pc_nxt = jump ? ctl.target : pc_r + PC_W'(1);
      if (ctl.fin) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

[hw/rtl/seqbm_dp.sv]
// ----------------------------------------------------------------------------
// seqbm_dp
// Datapath: request register, position arithmetic, reversal pointers,
// element store and result register.
// ----------------------------------------------------------------------------
module seqbm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  seqbm_pkg::in_t    in_data,
  input  seqbm_pkg::ctl_t   ctl,
  output seqbm_pkg::flags_t flags,
  output logic              out_valid,
  output seqbm_pkg::out_t   out_data
);
  import seqbm_pkg::*;

  localparam logic signed [CALC_W-1:0] ZERO_C = '0;
  localparam logic signed [CALC_W-1:0] ONE_C  = CALC_W'(1);

  in_t               req_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  p_r, q_r, l_r, m_r, h_r;
  logic [CNT_W-1:0]  lo_r, hi_r;
  logic [ADDR_W-1:0] plo_r, phi_r;
  logic              pend_r;
  logic [DATA_W-1:0] tmp_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic signed [CALC_W-1:0] a_x, len_x, b_x, n_x, p_x, q_x, m_x;
  logic signed [CALC_W-1:0] am1_c, bm1_c, room_q, room_u, d_c;
  logic signed [CALC_W-1:0] p_c, q_c, s_c, u_c, pq_c, hf_c;
  logic [CNT_W-1:0]         hi_m1;
  logic                     full, rd_ok;
  out_t                     res_c;

  // operand extension
  assign a_x   = CALC_W'(req_r.start_pos);
  assign len_x = CALC_W'(req_r.block_len);
  assign b_x   = CALC_W'(req_r.target_pos);
  assign n_x   = CALC_W'(cnt_r);
  assign p_x   = CALC_W'(p_r);
  assign q_x   = CALC_W'(q_r);
  assign m_x   = CALC_W'(m_r);

  // clipped block start and length
  assign am1_c  = a_x - ONE_C;
  assign p_c    = (am1_c < ZERO_C) ? ZERO_C : ((am1_c > n_x) ? n_x : am1_c);
  assign room_q = n_x - p_x;
  assign q_c    = (len_x > room_q) ? room_q : len_x;

  // backward destination
  assign bm1_c = b_x - ONE_C;
  assign s_c   = (bm1_c < ZERO_C) ? ZERO_C : ((bm1_c > p_x) ? p_x : bm1_c);
  assign pq_c  = p_x + q_x;

  // forward destination: skip u elements behind the block
  assign d_c    = b_x - a_x - len_x;
  assign room_u = n_x - m_x;
  assign u_c    = (d_c < ZERO_C) ? ZERO_C : ((d_c > room_u) ? room_u : d_c);
  assign hf_c   = m_x + u_c;

  // flags and status
  assign hi_m1      = hi_r - CNT_W'(1);
  assign flags.fwd  = (req_r.target_pos >= req_r.start_pos);
  assign flags.done = ({1'b0, lo_r} + (CNT_W + 1)'(1)) >= {1'b0, hi_r};
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign rd_ok      = (req_r.start_pos != '0) && (a_x <= n_x);

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (ctl.op)
      OP_APPEND: begin
        ram_we    = !full;
        ram_waddr = cnt_r[ADDR_W-1:0];
        ram_wdata = req_r.value_in;
      end
      OP_RD_ADDR: begin
        ram_raddr = am1_c[ADDR_W-1:0];
      end
      OP_SWAP_A: begin
        ram_raddr = lo_r[ADDR_W-1:0];
        ram_we    = pend_r;
        ram_waddr = plo_r;
        ram_wdata = ram_rdata;
      end
      OP_SWAP_B: begin
        ram_raddr = hi_m1[ADDR_W-1:0];
        ram_we    = pend_r;
        ram_waddr = phi_r;
        ram_wdata = tmp_r;
      end
      OP_DRAIN: begin
        ram_we    = pend_r;
        ram_waddr = phi_r;
        ram_wdata = tmp_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // result of the finishing step
  always_comb begin
    res_c.value_out = '0;
    res_c.status    = 1'b0;
    if (ctl.op == OP_RD_OUT) begin
      res_c.value_out = rd_ok ? ram_rdata : '0;
      res_c.status    = !rd_ok;
    end else if (ctl.op == OP_APPEND) begin
      res_c.status = full;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.fin;
      if (ctl.op == OP_APPEND && !full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (ctl.op == OP_SWAP_B) begin
        pend_r <= 1'b1;
      end else if (ctl.op == OP_INIT1 || ctl.op == OP_INIT2 || ctl.op == OP_INIT3 ||
                   ctl.op == OP_DRAIN) begin
        pend_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      req_r <= in_data;
    end
    if (ctl.fin) begin
      out_r <= res_c;
    end
    unique case (ctl.op)
      OP_CLIP_P: p_r <= p_c[CNT_W-1:0];
      OP_CLIP_Q: q_r <= q_c[CNT_W-1:0];
      OP_SET_BACK: begin
        l_r <= s_c[CNT_W-1:0];
        m_r <= p_r;
        h_r <= pq_c[CNT_W-1:0];
      end
      OP_SET_FWD0: begin
        l_r <= p_r;
        m_r <= pq_c[CNT_W-1:0];
      end
      OP_SET_FWD1: h_r <= hf_c[CNT_W-1:0];
      OP_INIT1: begin
        lo_r <= l_r;
        hi_r <= m_r;
      end
      OP_INIT2: begin
        lo_r <= m_r;
        hi_r <= h_r;
      end
      OP_INIT3: begin
        lo_r <= l_r;
        hi_r <= h_r;
      end
      OP_SWAP_B: begin
        tmp_r <= ram_rdata;
        plo_r <= lo_r[ADDR_W-1:0];
        phi_r <= hi_m1[ADDR_W-1:0];
        lo_r  <= lo_r + CNT_W'(1);
        hi_r  <= hi_m1;
      end
      default: begin
        tmp_r <= tmp_r;
      end
    endcase
  end

  // element store
  seqbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/sequence_block_mover.sv]
// ----------------------------------------------------------------------------
// sequence_block_mover
// Ordered sequence of up to DEPTH 32-bit values with append, block move and
// positional read, run by a microcoded sequencer over a single-port-pair RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; in_data holds
//   the request. Every transaction returns one result on out_data, marked by
//   out_valid for one cycle; the receiver cannot stall it.
//   Steps after acceptance (one control step per cycle, result registered
//   after the last step):
//     append, unused type : 1 step
//     read                : 2 steps
//     move                : clip and destination steps, then three reversals,
//                           each an init step, a swap loop and a drain step
//   A move is three in-place reversals; each swapped pair is read and written
//   back through the one read and one write port of the element store.
//   busy falls in the cycle the result is shown, so the next transaction can
//   be taken while out_valid is high.
//   Reset clears the element count; store contents are not cleared, and only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module sequence_block_mover (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  seqbm_pkg::in_t  in_data,
  output logic            out_valid,
  output seqbm_pkg::out_t out_data
);
  import seqbm_pkg::*;

  ctl_t   ctl;
  flags_t flags;
  logic   go;

  // transaction accept
  assign go = start && !busy;

  // sequencer
  seqbm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .req_type (in_data.req_type),
    .flags    (flags),
    .ctl      (ctl),
    .busy     (busy)
  );

  // datapath
  seqbm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .in_data   (in_data),
    .ctl       (ctl),
    .flags     (flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sim/tb_sequence_block_mover.sv]
// ----------------------------------------------------------------------------
// tb_sequence_block_mover
// Self-checking bench for the sequence block mover. A shadow copy of the
// sequence predicts every result: appends, clipped block moves, reads and
// unused request codes. The shadow is updated as each transaction is taken.
// Directed corner cases run first, then random traffic on a short sequence.
// Random idle gaps are inserted between requests.
// ----------------------------------------------------------------------------
module tb_sequence_block_mover;
  import seqbm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int SHORT_SEQ_MAX = 40;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // requests waiting to be driven and results waiting to come back
  in_t  request_queue [$];
  out_t result_queue [$];

  // shadow copy of the sequence
  logic [DATA_W-1:0] shadow_store [DEPTH];
  int shadow_count;

  int error_count;
  int gap_left;
  int calm_left;
  int idle_cycles;
  int plan_count;

  sequence_block_mover dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // rotate shadow entries lo..hi-1 left by k
  function automatic void rotate_shadow(input int lo, input int hi, input int k);
    logic [DATA_W-1:0] span_copy [$];
    int span;
    if (k == 0 || lo + k >= hi) return;
    span = hi - lo;
    for (int i = lo; i < hi; i++) span_copy.push_back(shadow_store[i]);
    for (int i = 0; i < span; i++) shadow_store[lo + i] = span_copy[(i + k) % span];
  endfunction

  // apply one request to the shadow and return the result it must give
  function automatic out_t apply_to_shadow(input in_t req);
    out_t res;
    int a, len, b, p, q, s, u;
    res = '0;
    a = int'(req.start_pos);
    len = int'(req.block_len);
    b = int'(req.target_pos);
    case (req.req_type)
      REQ_APPEND: begin
        if (shadow_count >= DEPTH) begin
          res.status = 1'b1;
        end else begin
          shadow_store[shadow_count] = req.value_in;
          shadow_count++;
        end
      end
      REQ_MOVE: begin
        p = clamp_int(a - 1, 0, shadow_count);
        q = clamp_int(len, 0, shadow_count - p);
        if (b < a) begin
          s = clamp_int(b - 1, 0, p);
          rotate_shadow(s, p + q, p - s);
        end else begin
          u = clamp_int(b - a - len, 0, shadow_count - p - q);
          rotate_shadow(p, p + q + u, q);
        end
      end
      REQ_READ: begin
        if (a >= 1 && a <= shadow_count) res.value_out = shadow_store[a - 1];
        else res.status = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // idle gap before the next request: mostly short, a few long, calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // position or length: mostly near the live range, sometimes any 11-bit value
  function automatic int pick_position(input int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    return $urandom_range(0, n + 2);
  endfunction

  task automatic queue_request(input logic [1:0] kind, input logic [DATA_W-1:0] value,
                               input int a, input int len, input int b);
    in_t req;
    req.req_type = kind;
    req.value_in = value;
    req.start_pos = a[POS_W-1:0];
    req.block_len = len[POS_W-1:0];
    req.target_pos = b[POS_W-1:0];
    request_queue.push_back(req);
    if (kind == REQ_APPEND && plan_count < DEPTH) plan_count++;
  endtask

  // driver: one transaction at a time, a random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) result_queue.push_back(apply_to_shadow(in_data));
      if (!start || !busy) begin
        if (start) gap_left = pick_gap();
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_queue.size() > 0) begin
          in_data <= request_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid) begin
      if (result_queue.size() == 0) begin
        $error("unexpected result: value_out %0d status %0d",
               out_data.value_out, out_data.status);
        error_count++;
      end else begin
        exp_res = result_queue.pop_front();
        if (out_data.value_out !== exp_res.value_out) begin
          $error("value_out expected %0d actual %0d", exp_res.value_out, out_data.value_out);
          error_count++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without an accepted request
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sequence_block_mover regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    error_count = 0;
    gap_left = 0;
    calm_left = 0;
    idle_cycles = 0;
    shadow_count = 0;
    plan_count = 0;

    // corner cases on an empty and then a short sequence
    queue_request(REQ_READ, '0, 1, 0, 0);
    queue_request(REQ_MOVE, '0, 1, 5, 3);
    queue_request(REQ_APPEND, 32'h8000_0000, 0, 0, 0);
    queue_request(REQ_APPEND, 32'h7FFF_FFFF, 2047, 2047, 2047);
    queue_request(REQ_APPEND, 32'h0000_0000, 0, 0, 0);
    queue_request(REQ_APPEND, 32'hFFFF_FFFF, 0, 0, 0);
    queue_request(REQ_APPEND, 32'h5A5A_A5A5, 0, 0, 0);
    queue_request(REQ_APPEND, 32'h1234_5678, 0, 0, 0);
    queue_request(REQ_READ, '0, 0, 0, 0);
    queue_request(REQ_READ, '0, 1, 0, 0);
    queue_request(REQ_READ, '0, 6, 0, 0);
    queue_request(REQ_READ, '0, 7, 0, 0);
    queue_request(REQ_READ, '0, 2047, 0, 0);
    queue_request(REQ_MOVE, '0, 4, 2, 2);
    queue_request(REQ_MOVE, '0, 1, 2, 5);
    queue_request(REQ_MOVE, '0, 2, 0, 5);
    queue_request(REQ_MOVE, '0, 0, 3, 2047);
    queue_request(REQ_MOVE, '0, 2047, 2047, 0);
    queue_request(REQ_MOVE, '0, 3, 2047, 1);
    queue_request(REQ_MOVE, '0, 5, 1, 0);
    queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 2047, 2047, 2047);
    queue_request(REQ_READ, '0, 2, 0, 0);
    queue_request(REQ_READ, '0, 3, 0, 0);
    queue_request(REQ_READ, '0, 4, 0, 0);
    queue_request(REQ_READ, '0, 5, 0, 0);

    // random traffic on a short sequence
    for (int i = 0; i < 265; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 && plan_count < SHORT_SEQ_MAX)
        queue_request(REQ_APPEND, $urandom, $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
      else if (pick < 65)
        queue_request(REQ_MOVE, $urandom, pick_position(plan_count),
                      pick_position(plan_count), pick_position(plan_count));
      else if (pick < 95)
        queue_request(REQ_READ, $urandom, pick_position(plan_count),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        queue_request(REQ_UNUSED, $urandom, $urandom_range(0, 2047),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken and answered
    while (request_queue.size() > 0 || start || result_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("sequence_block_mover regression: pass");
    end else begin
      $display("sequence_block_mover regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/seqbm_pkg.sv
hw/rtl/seqbm_ram.sv
hw/rtl/seqbm_seq.sv
hw/rtl/seqbm_dp.sv
hw/rtl/sequence_block_mover.sv
sim/tb_sequence_block_mover.sv
